@@ src/smrrb_pkg.sv @@
package smrrb_pkg;

  localparam int MAX_SECTIONS       = 16;
  localparam int MAX_RECEIVERS      = 8;
  localparam int MAX_SECTION_LENGTH = 256;
  localparam int STORE_DEPTH        = MAX_SECTIONS * MAX_SECTION_LENGTH;
  localparam int SEC_W              = $clog2(MAX_SECTIONS);
  localparam int ADDR_W             = $clog2(STORE_DEPTH);
  localparam int TOTAL_W            = ADDR_W + 1;

  localparam logic [2:0] OP_PUSH    = 3'd0;
  localparam logic [2:0] OP_PARTIAL = 3'd1;
  localparam logic [2:0] OP_PUBLISH = 3'd2;
  localparam logic [2:0] OP_ACK     = 3'd3;
  localparam logic [2:0] OP_READ    = 3'd4;
  localparam logic [2:0] OP_CLEAR   = 3'd5;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_RECEIVER = 2'd1;
  localparam logic [1:0] ERR_GROUP    = 2'd2;

  localparam logic [1:0] REG_SECTIONS  = 2'd0;
  localparam logic [1:0] REG_LENGTH    = 2'd1;
  localparam logic [1:0] REG_RECEIVERS = 2'd2;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] sample;
    logic [2:0]         receiver;
    logic [4:0]         group_sections;
    logic [11:0]        read_offset;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_data;
    logic               compute_ready;
    logic               record_ready;
    logic               advanced;
    logic [11:0]        fill_index;
    logic [3:0]         record_index;
    logic [3:0]         compute_index;
    logic [1:0]         error;
  } out_item_t;

endpackage

@@ src/sectioned_multi_reader_ring_buffer.sv @@
// Steps: execute; partial ack marks g sections (g = group_sections); publish multiplies,
//   compares, then walks g sections if it advances; acknowledge checks g sections and sets
//   them if all are marked; read does a multiply, 13-step modulo and store read; then a
//   flag query over g sections. A rejected item (receiver or group error) goes to done.
// One item at a time; in_ready stays low from accept until the result is registered.
// Reset: synchronous, active high; registers, positions, flags reset; store not cleared.
module sectioned_multi_reader_ring_buffer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  smrrb_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output smrrb_pkg::out_item_t out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import smrrb_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b00000000001,
    ST_EXEC   = 11'b00000000010,
    ST_WALK   = 11'b00000000100,
    ST_MUL    = 11'b00000001000,
    ST_CMP    = 11'b00000010000,
    ST_MOD    = 11'b00000100000,
    ST_RDMEM  = 11'b00001000000,
    ST_RDDATA = 11'b00010000000,
    ST_QUERY  = 11'b00100000000,
    ST_FLAGS  = 11'b01000000000,
    ST_DONE   = 11'b10000000000
  } state_t;

  typedef enum logic [1:0] {
    WK_MARK,
    WK_PUB,
    WK_ACKCHK,
    WK_ACKSET
  } walk_t;

  state_t state;
  walk_t  mode;

  logic [4:0] sections_in_use;
  logic [8:0] section_length;
  logic [3:0] receivers_in_use;

  logic [ADDR_W-1:0] fill;
  logic [SEC_W-1:0]  record_section;
  logic [SEC_W-1:0]  compute_section;
  logic [MAX_SECTIONS-1:0] published;
  logic [MAX_SECTIONS-1:0] acknowledged;
  logic [MAX_RECEIVERS-1:0] marks [MAX_SECTIONS];

  logic [31:0] store [STORE_DEPTH];
  logic [31:0] mem_q;

  logic [2:0]        op_q;
  logic [31:0]       sample_q;
  logic [2:0]        rcv_q;
  logic [4:0]        g_q;
  logic [11:0]       off_q;
  logic [1:0]        err_q;
  logic [4:0]        k;
  logic [SEC_W-1:0]  ci;
  logic [SEC_W-1:0]  ri;
  logic [SEC_W-1:0]  endsec;
  logic              cr;
  logic              rr;
  logic              all_ok;
  logic              adv;
  logic [31:0]       rd;
  logic [TOTAL_W-1:0] prod;
  logic [TOTAL_W-1:0] rem;
  logic [3:0]        step;

  logic [4:0]         s_eff;
  logic [8:0]         l_eff;
  logic [3:0]         r_eff;
  logic [TOTAL_W-1:0] total;
  logic [MAX_RECEIVERS-1:0] need;
  logic [1:0]         err_in;
  logic               accept;
  logic               cfg_write;
  logic               last;
  logic               out_load;
  logic [4:0]         pub_sum;
  logic [SEC_W-1:0]   pub_end;
  logic [4:0]         cmp_sum;
  logic [SEC_W-1:0]   cmp_end;
  logic [TOTAL_W:0]   fill_inc;
  logic [SEC_W-1:0]   mul_a;
  logic [TOTAL_W+11:0] mod_sub;
  logic               ack_hit;

  function automatic logic [SEC_W-1:0] nxt_idx(input logic [SEC_W-1:0] i,
                                               input logic [4:0] s);
    logic [4:0] n;
    n = {1'b0, i} + 5'd1;
    return (n >= s) ? '0 : n[SEC_W-1:0];
  endfunction

  always_comb begin
    s_eff = (sections_in_use == 5'd0) ? 5'd1 :
            (sections_in_use > 5'(MAX_SECTIONS)) ? 5'(MAX_SECTIONS) : sections_in_use;
    l_eff = (section_length == 9'd0) ? 9'd1 :
            (section_length > 9'(MAX_SECTION_LENGTH)) ? 9'(MAX_SECTION_LENGTH) : section_length;
    r_eff = (receivers_in_use == 4'd0) ? 4'd1 :
            (receivers_in_use > 4'(MAX_RECEIVERS)) ? 4'(MAX_RECEIVERS) : receivers_in_use;
    total = TOTAL_W'(s_eff * l_eff);
    need  = MAX_RECEIVERS'((9'd1 << r_eff) - 9'd1);
  end

  always_comb begin
    priority if ({1'b0, in_data.receiver} >= r_eff) err_in = ERR_RECEIVER;
    else if (in_data.group_sections == 5'd0 || in_data.group_sections > s_eff)
      err_in = ERR_GROUP;
    else err_in = ERR_NONE;
  end

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign last      = (k == g_q - 5'd1);
  assign out_load  = (state == ST_DONE) && (!out_valid || out_ready);

  assign pub_sum  = {1'b0, record_section} + g_q;
  assign pub_end  = SEC_W'((pub_sum >= s_eff) ? pub_sum - s_eff : pub_sum);
  assign cmp_sum  = {1'b0, compute_section} + g_q;
  assign cmp_end  = SEC_W'((cmp_sum >= s_eff) ? cmp_sum - s_eff : cmp_sum);
  assign fill_inc = {2'b0, fill} + (TOTAL_W+1)'(1);
  assign mul_a    = (op_q == OP_PUBLISH) ? ((endsec == '0) ? record_section : endsec)
                                         : compute_section;
  assign mod_sub  = {12'b0, total} << step;
  assign ack_hit  = ((marks[ci] & need) == need);

  always_comb begin
    unique case (paddr[3:2])
      REG_SECTIONS:  prdata = {27'b0, sections_in_use};
      REG_LENGTH:    prdata = {23'b0, section_length};
      REG_RECEIVERS: prdata = {28'b0, receivers_in_use};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      mode             <= WK_MARK;
      out_valid        <= 1'b0;
      sections_in_use  <= 5'd4;
      section_length   <= 9'd64;
      receivers_in_use <= 4'd1;
      fill             <= '0;
      record_section   <= '0;
      compute_section  <= '0;
      published        <= '0;
      acknowledged     <= '1;
      for (int i = 0; i < MAX_SECTIONS; i++) marks[i] <= '0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      if (cfg_write) begin
        unique case (paddr[3:2])
          REG_SECTIONS, REG_LENGTH: begin
            if (paddr[3:2] == REG_SECTIONS) sections_in_use <= pwdata[4:0];
            else section_length <= pwdata[8:0];
            fill            <= '0;
            record_section  <= '0;
            compute_section <= '0;
            published       <= '0;
            acknowledged    <= '1;
            for (int i = 0; i < MAX_SECTIONS; i++) marks[i] <= '0;
          end
          REG_RECEIVERS: receivers_in_use <= pwdata[3:0];
          default: ;
        endcase
      end

      unique case (state)
        ST_IDLE: if (accept) state <= ST_EXEC;
        ST_EXEC: begin
          if (err_q != ERR_NONE) state <= ST_DONE;
          else begin
            unique case (op_q)
              OP_PUSH: begin
                fill  <= (fill_inc >= {1'b0, total}) ? '0 : fill_inc[ADDR_W-1:0];
                state <= ST_QUERY;
              end
              OP_PARTIAL: begin
                mode  <= WK_MARK;
                state <= ST_WALK;
              end
              OP_PUBLISH, OP_READ: state <= ST_MUL;
              OP_ACK: begin
                mode  <= WK_ACKCHK;
                state <= ST_WALK;
              end
              OP_CLEAR: begin
                fill            <= '0;
                record_section  <= '0;
                compute_section <= '0;
                published       <= '0;
                acknowledged    <= '1;
                for (int i = 0; i < MAX_SECTIONS; i++) marks[i] <= '0;
                state <= ST_QUERY;
              end
              default: state <= ST_QUERY;
            endcase
          end
        end
        ST_MUL: state <= ST_CMP;
        ST_CMP: begin
          if (op_q == OP_PUBLISH) begin
            if ((endsec == '0) ? ({1'b0, fill} < prod) : ({1'b0, fill} >= prod)) begin
              mode  <= WK_PUB;
              state <= ST_WALK;
            end else state <= ST_QUERY;
          end else state <= ST_MOD;
        end
        ST_MOD: if (step == 4'd0) state <= ST_RDMEM;
        ST_RDMEM: state <= ST_RDDATA;
        ST_RDDATA: state <= ST_QUERY;
        ST_WALK: begin
          unique case (mode)
            WK_MARK: begin
              marks[ci][rcv_q] <= 1'b1;
              if (last) state <= ST_QUERY;
            end
            WK_PUB: begin
              published[ri]    <= 1'b1;
              acknowledged[ri] <= 1'b0;
              marks[ri]        <= '0;
              if (last) begin
                record_section <= endsec;
                state          <= ST_QUERY;
              end
            end
            WK_ACKCHK: begin
              if (last) begin
                if (all_ok && ack_hit) mode <= WK_ACKSET;
                else state <= ST_QUERY;
              end
            end
            WK_ACKSET: begin
              acknowledged[ci] <= 1'b1;
              published[ci]    <= 1'b0;
              if (last) begin
                compute_section <= cmp_end;
                state           <= ST_QUERY;
              end
            end
          endcase
        end
        ST_QUERY: state <= ST_FLAGS;
        ST_FLAGS: if (last) state <= ST_DONE;
        ST_DONE: if (out_load) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          op_q     <= in_data.op;
          sample_q <= in_data.sample;
          rcv_q    <= in_data.receiver;
          g_q      <= in_data.group_sections;
          off_q    <= in_data.read_offset;
          err_q    <= err_in;
          adv      <= 1'b0;
          rd       <= '0;
          cr       <= 1'b0;
          rr       <= 1'b0;
        end
      end
      ST_EXEC: begin
        k      <= '0;
        ci     <= compute_section;
        ri     <= record_section;
        all_ok <= 1'b1;
        endsec <= pub_end;
      end
      ST_MUL: prod <= TOTAL_W'(mul_a * l_eff);
      ST_CMP: begin
        rem  <= prod + TOTAL_W'(off_q);
        step <= 4'(TOTAL_W - 1);
      end
      ST_MOD: begin
        if ({12'b0, rem} >= mod_sub) rem <= rem - mod_sub[TOTAL_W-1:0];
        if (step != 4'd0) step <= step - 4'd1;
      end
      ST_RDMEM: ;
      ST_RDDATA: rd <= mem_q;
      ST_WALK: begin
        k  <= last ? '0 : k + 5'd1;
        ci <= (mode == WK_ACKCHK && last) ? compute_section : nxt_idx(ci, s_eff);
        ri <= nxt_idx(ri, s_eff);
        unique case (mode)
          WK_MARK: ;
          WK_PUB: if (last) adv <= 1'b1;
          WK_ACKCHK: if (!ack_hit) all_ok <= 1'b0;
          WK_ACKSET: if (last) adv <= 1'b1;
        endcase
      end
      ST_QUERY: begin
        k  <= '0;
        ci <= compute_section;
        ri <= record_section;
        cr <= 1'b1;
        rr <= 1'b1;
      end
      ST_FLAGS: begin
        k  <= k + 5'd1;
        ci <= nxt_idx(ci, s_eff);
        ri <= nxt_idx(ri, s_eff);
        if (!published[ci] || marks[ci][rcv_q]) cr <= 1'b0;
        if (!acknowledged[ri]) rr <= 1'b0;
      end
      ST_DONE: begin
        if (out_load) begin
          out_data.read_data     <= rd;
          out_data.compute_ready <= cr;
          out_data.record_ready  <= rr;
          out_data.advanced      <= adv;
          out_data.fill_index    <= 12'(fill);
          out_data.record_index  <= 4'(record_section);
          out_data.compute_index <= 4'(compute_section);
          out_data.error         <= err_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_EXEC && err_q == ERR_NONE && op_q == OP_PUSH) store[fill] <= sample_q;
    mem_q <= store[rem[ADDR_W-1:0]];
  end

endmodule

@@ src/smrrb_checker.sv @@
module smrrb_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input smrrb_pkg::out_item_t out_data
);
  import smrrb_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again before the item finished");

  a_error_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.error != ERR_NONE |->
      !out_data.advanced && !out_data.compute_ready && !out_data.record_ready &&
      out_data.read_data == 0)
    else $error("rejected transfer reports activity");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind sectioned_multi_reader_ring_buffer smrrb_checker u_smrrb_checker (.*);
